@@ rtl/core/int8_int4_group_dequant_mac_assert.svh @@
// Assertion macros for the group dequantizing MAC.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef INT8_INT4_GROUP_DEQUANT_MAC_ASSERT_SVH
`define INT8_INT4_GROUP_DEQUANT_MAC_ASSERT_SVH
`ifndef SYNTHESIS
// Property must hold at every sampled edge.
`define I8I4GDM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression must never be true at a sampled edge.
`define I8I4GDM_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define I8I4GDM_ASSERT(lbl, prop, msg)
`define I8I4GDM_NEVER(lbl, expr, msg)
`endif
`endif

@@ rtl/core/i8i4gdm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package i8i4gdm_pkg;

    // Datapath geometry.
    localparam int COLUMN_LANES  = 2;
    localparam int FRACTION_BITS = 16;
    localparam int ACC_WIDTH     = 48;
    localparam int OUT_WIDTH     = 48;

    localparam int BYTE_W   = 8;
    localparam int NIBBLE_W = BYTE_W / COLUMN_LANES;
    localparam logic [NIBBLE_W-1:0] NIBBLE_MASK = NIBBLE_W'(4'hf);

    localparam int SCALE_W = 31;
    localparam int WORD_W  = 32;
    localparam int BIAS_W  = 32;
    localparam int DIFF_W  = BYTE_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;

    // Scaling product widths: magnitude * act scale, then split by 32 bits.
    localparam int MAG_W = WORD_W;
    localparam int M_W   = MAG_W + SCALE_W;
    localparam int MHI_W = M_W - WORD_W;
    localparam int LO_W  = WORD_W + SCALE_W;
    localparam int MID_W = MHI_W + SCALE_W;
    localparam int TOT_W = MID_W + WORD_W + 1;
    localparam int Q_W   = TOT_W - FRACTION_BITS;
    localparam int EXT_W = (ACC_WIDTH > OUT_WIDTH) ? ACC_WIDTH : OUT_WIDTH;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WORD_W-1:0] GSUM_MAX = {1'b0, {(WORD_W - 1){1'b1}}};
    localparam logic [WORD_W-1:0] GSUM_MIN = {1'b1, {(WORD_W - 1){1'b0}}};
    localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH - 1){1'b1}}};
    localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH - 1){1'b0}}};
    localparam logic [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH - 1){1'b1}}};
    localparam logic [OUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUT_WIDTH - 1){1'b0}}};
    localparam logic signed [EXT_W-1:0] OUT_MAX_EXT = EXT_W'(OUT_MAX);
    localparam logic signed [EXT_W-1:0] OUT_MIN_EXT = EXT_W'($signed(OUT_MIN));
    localparam logic [Q_W-1:0] Q_LIM_POS = Q_W'(ACC_MAX);
    localparam logic [TOT_W-1:0] ROUND_HALF = TOT_W'(1) << (FRACTION_BITS - 1);

    typedef struct packed {
        logic [7:0]         act_byte;
        logic [7:0]         act_zero;
        logic [30:0]        act_scale;
        logic [7:0]         weight_pair;
        logic signed [7:0]  wzero_even;
        logic signed [7:0]  wzero_odd;
        logic [30:0]        wscale_even;
        logic [30:0]        wscale_odd;
        logic               group_last;
        logic               row_last;
        logic signed [31:0] bias_even;
        logic signed [31:0] bias_odd;
    } step_t;

    typedef struct packed {
        logic signed [47:0] out_even;
        logic signed [47:0] out_odd;
        logic               saturated;
    } result_t;

    // One finished group handed from the front to the back.
    typedef struct packed {
        logic [COLUMN_LANES-1:0][WORD_W-1:0]  gsum;
        logic [SCALE_W-1:0]                   ascale;
        logic [COLUMN_LANES-1:0][SCALE_W-1:0] wscale;
        logic [COLUMN_LANES-1:0][BIAS_W-1:0]  bias;
        logic                                 row_end;
        logic                                 sat;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [8:0] {
        B_IDLE  = 9'b000000001,
        B_MULA  = 9'b000000010,
        B_MULLO = 9'b000000100,
        B_MULHI = 9'b000001000,
        B_SUM   = 9'b000010000,
        B_TERM  = 9'b000100000,
        B_ACC   = 9'b001000000,
        B_BIAS  = 9'b010000000,
        B_OUT   = 9'b100000000
    } back_state_t;

endpackage

`default_nettype wire

@@ rtl/core/i8i4gdm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module i8i4gdm_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step_valid,
    output logic                      step_ready,
    input  wire i8i4gdm_pkg::step_t   step,
    input  wire i8i4gdm_pkg::q_stat_t q_stat,
    output logic                      push,
    output i8i4gdm_pkg::job_t         job
);

    logic [i8i4gdm_pkg::COLUMN_LANES-1:0][i8i4gdm_pkg::WORD_W-1:0] gsum_reg, gsum_next;
    logic sat_reg, sat_next;

    logic signed [i8i4gdm_pkg::DIFF_W-1:0] act_d;
    logic signed [7:0] wz [i8i4gdm_pkg::COLUMN_LANES];
    logic [i8i4gdm_pkg::NIBBLE_W-1:0] nib [i8i4gdm_pkg::COLUMN_LANES];
    logic signed [i8i4gdm_pkg::DIFF_W-1:0] w_d [i8i4gdm_pkg::COLUMN_LANES];
    logic signed [i8i4gdm_pkg::PROD_W-1:0] prod [i8i4gdm_pkg::COLUMN_LANES];
    logic [i8i4gdm_pkg::WORD_W:0] sum_w [i8i4gdm_pkg::COLUMN_LANES];
    logic [i8i4gdm_pkg::COLUMN_LANES-1:0][i8i4gdm_pkg::WORD_W-1:0] clipped;
    logic [i8i4gdm_pkg::COLUMN_LANES-1:0] ovf;
    logic accept;
    logic grp_end;

    assign step_ready = !q_stat.full;
    assign accept     = step_valid && step_ready;
    assign grp_end    = step.group_last || step.row_last;
    assign push       = accept && grp_end;

    // Zero-point correction, product and saturating group sum, one lane per column.
    always_comb
    begin
        act_d = i8i4gdm_pkg::DIFF_W'(step.act_byte) - i8i4gdm_pkg::DIFF_W'(step.act_zero);
        wz[0] = step.wzero_even;
        wz[1] = step.wzero_odd;
        for (int l = 0; l < i8i4gdm_pkg::COLUMN_LANES; l++)
        begin
            nib[l] = i8i4gdm_pkg::NIBBLE_W'(step.weight_pair >> (l * i8i4gdm_pkg::NIBBLE_W))
                     & i8i4gdm_pkg::NIBBLE_MASK;
            w_d[l] = i8i4gdm_pkg::DIFF_W'(nib[l]) - i8i4gdm_pkg::DIFF_W'(wz[l]);
            prod[l] = act_d * w_d[l];
            sum_w[l] = (i8i4gdm_pkg::WORD_W + 1)'($signed(gsum_reg[l]))
                     + (i8i4gdm_pkg::WORD_W + 1)'(prod[l]);
            ovf[l] = sum_w[l][i8i4gdm_pkg::WORD_W] ^ sum_w[l][i8i4gdm_pkg::WORD_W-1];
            if (ovf[l])
                clipped[l] = sum_w[l][i8i4gdm_pkg::WORD_W] ? i8i4gdm_pkg::GSUM_MIN
                                                           : i8i4gdm_pkg::GSUM_MAX;
            else
                clipped[l] = sum_w[l][i8i4gdm_pkg::WORD_W-1:0];
        end
    end

    always_comb
    begin
        gsum_next = gsum_reg;
        sat_next  = sat_reg;
        if (accept)
        begin
            if (grp_end)
            begin
                gsum_next = '0;
                sat_next  = 1'b0;
            end
            else
            begin
                gsum_next = clipped;
                sat_next  = sat_reg || (|ovf);
            end
        end
    end

    always_comb
    begin
        job.gsum      = clipped;
        job.ascale    = step.act_scale;
        job.wscale[0] = step.wscale_even;
        job.wscale[1] = step.wscale_odd;
        job.bias[0]   = step.bias_even;
        job.bias[1]   = step.bias_odd;
        job.row_end   = step.row_last;
        job.sat       = sat_reg || (|ovf);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gsum_reg <= '0;
            sat_reg  <= 1'b0;
        end
        else
        begin
            gsum_reg <= gsum_next;
            sat_reg  <= sat_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/i8i4gdm_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module i8i4gdm_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire i8i4gdm_pkg::job_t push_job,
    input  wire logic              pop,
    output i8i4gdm_pkg::job_t      head,
    output i8i4gdm_pkg::q_stat_t   q_stat
);

    i8i4gdm_pkg::job_t slot_reg [i8i4gdm_pkg::QUEUE_DEPTH];
    logic [i8i4gdm_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [i8i4gdm_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [i8i4gdm_pkg::QCNT_W-1:0] count_reg, count_next;

    assign head         = slot_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == i8i4gdm_pkg::QCNT_W'(i8i4gdm_pkg::QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == i8i4gdm_pkg::QPTR_W'(i8i4gdm_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == i8i4gdm_pkg::QPTR_W'(i8i4gdm_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + i8i4gdm_pkg::QCNT_W'(push) - i8i4gdm_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

@@ rtl/core/i8i4gdm_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module i8i4gdm_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire i8i4gdm_pkg::q_stat_t q_stat,
    input  wire i8i4gdm_pkg::job_t    head,
    output logic                      pop,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output i8i4gdm_pkg::result_t      result
);

    localparam int L = i8i4gdm_pkg::COLUMN_LANES;
    localparam int A = i8i4gdm_pkg::ACC_WIDTH;

    i8i4gdm_pkg::back_state_t state_reg, state_next;

    logic [L-1:0][i8i4gdm_pkg::MAG_W-1:0]   mag_reg, mag_next;
    logic [L-1:0]                           neg_reg, neg_next;
    logic [i8i4gdm_pkg::SCALE_W-1:0]        ascale_reg;
    logic [L-1:0][i8i4gdm_pkg::SCALE_W-1:0] wscale_reg;
    logic [L-1:0][i8i4gdm_pkg::BIAS_W-1:0]  bias_reg;
    logic                                   row_end_reg;
    logic [L-1:0][i8i4gdm_pkg::M_W-1:0]     m_reg, m_next;
    logic [L-1:0][i8i4gdm_pkg::LO_W-1:0]    lo_reg, lo_next;
    logic [L-1:0][i8i4gdm_pkg::MID_W-1:0]   mid_reg, mid_next;
    logic [L-1:0][i8i4gdm_pkg::TOT_W-1:0]   tot_reg, tot_next;
    logic [L-1:0][A-1:0]                    term_reg, term_next;
    logic [L-1:0][A-1:0]                    acc_reg, acc_next, acc_sum;
    logic [L-1:0][A-1:0]                    biased_reg, biased_next;
    logic                                   sat_reg, sat_next;
    i8i4gdm_pkg::result_t                   res_reg, res_next;
    logic                                   res_valid_reg, res_valid_next;

    logic [i8i4gdm_pkg::Q_W-1:0] q [L];
    logic [i8i4gdm_pkg::Q_W-1:0] lim [L];
    logic [i8i4gdm_pkg::Q_W-1:0] qc [L];
    logic [A:0] sum_a [L];
    logic [A:0] sum_b [L];
    logic signed [i8i4gdm_pkg::EXT_W-1:0] ext [L];
    logic [i8i4gdm_pkg::OUT_WIDTH-1:0] out_val [L];
    logic [L-1:0] q_sat, a_ovf, b_ovf, o_hi, o_lo;
    logic out_load;

    assign pop      = (state_reg == i8i4gdm_pkg::B_IDLE) && !q_stat.empty;
    assign out_load = (state_reg == i8i4gdm_pkg::B_OUT) && (!res_valid_reg || result_ready);

    // Lane arithmetic; each step reads registers written by earlier steps.
    always_comb
    begin
        for (int l = 0; l < L; l++)
        begin
            neg_next[l] = head.gsum[l][i8i4gdm_pkg::WORD_W-1];
            mag_next[l] = neg_next[l] ? ('0 - head.gsum[l]) : head.gsum[l];

            m_next[l] = i8i4gdm_pkg::M_W'(mag_reg[l]) * i8i4gdm_pkg::M_W'(ascale_reg);
            lo_next[l] = i8i4gdm_pkg::LO_W'(m_reg[l][i8i4gdm_pkg::WORD_W-1:0])
                       * i8i4gdm_pkg::LO_W'(wscale_reg[l]);
            mid_next[l] = i8i4gdm_pkg::MID_W'(m_reg[l][i8i4gdm_pkg::M_W-1:i8i4gdm_pkg::WORD_W])
                        * i8i4gdm_pkg::MID_W'(wscale_reg[l]);
            tot_next[l] = i8i4gdm_pkg::TOT_W'(lo_reg[l])
                        + (i8i4gdm_pkg::TOT_W'(mid_reg[l]) << i8i4gdm_pkg::WORD_W)
                        + i8i4gdm_pkg::ROUND_HALF;

            // Rounded magnitude, clipped to the accumulator range for its sign.
            q[l]     = tot_reg[l][i8i4gdm_pkg::TOT_W-1:i8i4gdm_pkg::FRACTION_BITS];
            lim[l]   = i8i4gdm_pkg::Q_LIM_POS + i8i4gdm_pkg::Q_W'(neg_reg[l]);
            q_sat[l] = q[l] > lim[l];
            qc[l]    = q_sat[l] ? lim[l] : q[l];
            term_next[l] = neg_reg[l] ? A'(i8i4gdm_pkg::Q_W'(0) - qc[l]) : A'(qc[l]);

            sum_a[l] = (A + 1)'($signed(acc_reg[l])) + (A + 1)'($signed(term_reg[l]));
            a_ovf[l] = sum_a[l][A] ^ sum_a[l][A-1];
            if (a_ovf[l])
                acc_sum[l] = sum_a[l][A] ? i8i4gdm_pkg::ACC_MIN : i8i4gdm_pkg::ACC_MAX;
            else
                acc_sum[l] = sum_a[l][A-1:0];

            sum_b[l] = (A + 1)'($signed(acc_reg[l])) + (A + 1)'($signed(bias_reg[l]));
            b_ovf[l] = sum_b[l][A] ^ sum_b[l][A-1];
            if (b_ovf[l])
                biased_next[l] = sum_b[l][A] ? i8i4gdm_pkg::ACC_MIN : i8i4gdm_pkg::ACC_MAX;
            else
                biased_next[l] = sum_b[l][A-1:0];

            ext[l]  = i8i4gdm_pkg::EXT_W'($signed(biased_reg[l]));
            o_hi[l] = ext[l] > i8i4gdm_pkg::OUT_MAX_EXT;
            o_lo[l] = ext[l] < i8i4gdm_pkg::OUT_MIN_EXT;
            if (o_hi[l])
                out_val[l] = i8i4gdm_pkg::OUT_MAX;
            else if (o_lo[l])
                out_val[l] = i8i4gdm_pkg::OUT_MIN;
            else
                out_val[l] = ext[l][i8i4gdm_pkg::OUT_WIDTH-1:0];
        end
    end

    always_comb
    begin
        res_next.out_even  = out_val[0];
        res_next.out_odd   = out_val[1];
        res_next.saturated = sat_reg || (|o_hi) || (|o_lo);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            i8i4gdm_pkg::B_IDLE:  if (!q_stat.empty) state_next = i8i4gdm_pkg::B_MULA;
            i8i4gdm_pkg::B_MULA:  state_next = i8i4gdm_pkg::B_MULLO;
            i8i4gdm_pkg::B_MULLO: state_next = i8i4gdm_pkg::B_MULHI;
            i8i4gdm_pkg::B_MULHI: state_next = i8i4gdm_pkg::B_SUM;
            i8i4gdm_pkg::B_SUM:   state_next = i8i4gdm_pkg::B_TERM;
            i8i4gdm_pkg::B_TERM:  state_next = i8i4gdm_pkg::B_ACC;
            i8i4gdm_pkg::B_ACC:
                state_next = row_end_reg ? i8i4gdm_pkg::B_BIAS : i8i4gdm_pkg::B_IDLE;
            i8i4gdm_pkg::B_BIAS:  state_next = i8i4gdm_pkg::B_OUT;
            i8i4gdm_pkg::B_OUT:   if (out_load) state_next = i8i4gdm_pkg::B_IDLE;
            default:              state_next = i8i4gdm_pkg::B_IDLE;
        endcase
    end

    // Row state: accumulator and the sticky saturation flag.
    always_comb
    begin
        acc_next = acc_reg;
        sat_next = sat_reg;
        if (pop)
            sat_next = sat_reg || head.sat;
        if (state_reg == i8i4gdm_pkg::B_TERM)
            sat_next = sat_reg || (|q_sat);
        if (state_reg == i8i4gdm_pkg::B_ACC)
        begin
            acc_next = acc_sum;
            sat_next = sat_reg || (|a_ovf);
        end
        if (state_reg == i8i4gdm_pkg::B_BIAS)
            sat_next = sat_reg || (|b_ovf);
        if (out_load)
        begin
            acc_next = '0;
            sat_next = 1'b0;
        end
    end

    assign res_valid_next = out_load || (res_valid_reg && !result_ready);
    assign result_valid   = res_valid_reg;
    assign result         = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= i8i4gdm_pkg::B_IDLE;
            acc_reg       <= '0;
            sat_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            sat_reg       <= sat_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            mag_reg     <= mag_next;
            neg_reg     <= neg_next;
            ascale_reg  <= head.ascale;
            wscale_reg  <= head.wscale;
            bias_reg    <= head.bias;
            row_end_reg <= head.row_end;
        end
        if (state_reg == i8i4gdm_pkg::B_MULA)
            m_reg <= m_next;
        if (state_reg == i8i4gdm_pkg::B_MULLO)
            lo_reg <= lo_next;
        if (state_reg == i8i4gdm_pkg::B_MULHI)
            mid_reg <= mid_next;
        if (state_reg == i8i4gdm_pkg::B_SUM)
            tot_reg <= tot_next;
        if (state_reg == i8i4gdm_pkg::B_TERM)
            term_reg <= term_next;
        if (state_reg == i8i4gdm_pkg::B_BIAS)
            biased_reg <= biased_next;
        if (out_load)
            res_reg <= res_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/int8_int4_group_dequant_mac.sv @@
// Two-column W4A8 group-quantized multiply-accumulate with dequantization.
// Input channel: step_valid / step_ready / step. Each word carries one activation
// byte, one byte with two 4-bit weights, the zero points and scales of the current
// group, the group and row end marks, and the biases used at a row end.
// Output channel: result_valid / result_ready / result. One word leaves per row,
// holding both column results and a flag that some step of the row saturated.
// The front takes one input word per cycle while the queue is not full and folds
// it into the group sums. A word that ends a group is placed in a two-entry queue;
// the back drains it through a sequencer that shares no state with the front:
// scaling steps through pop, two 32x31 multiplies and one 31x31, rounding add,
// clip and accumulate, and a row end adds bias and output load. The back takes
// the next group only from its idle step, so words stream at one per cycle while
// the back keeps pace with the groups; groups too short for that are paced by
// the back once the queue is full.
// The result sits in an output register, so a stalled receiver only holds the
// back in its output step; the front keeps accepting until the queue fills.
// Reset clears the group sums, the row accumulators, the saturation flags, the
// queue and the output valid; the block accepts words as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

`include "int8_int4_group_dequant_mac_assert.svh"

module int8_int4_group_dequant_mac (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step_valid,
    output logic                      step_ready,
    input  wire i8i4gdm_pkg::step_t   step,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output i8i4gdm_pkg::result_t      result
);

    // Queue traffic between the front and the back.
    i8i4gdm_pkg::job_t    q_push_job;
    i8i4gdm_pkg::job_t    q_head;
    i8i4gdm_pkg::q_stat_t q_stat;
    logic                 q_push;
    logic                 q_pop;

    // The front does the per-word work and hands finished groups on.
    i8i4gdm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (step_valid),
        .step_ready (step_ready),
        .step       (step),
        .q_stat     (q_stat),
        .push       (q_push),
        .job        (q_push_job)
    );

    // Two entries let the front run ahead while the back scales a group.
    i8i4gdm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_push_job),
        .pop      (q_pop),
        .head     (q_head),
        .q_stat   (q_stat)
    );

    // The back scales group sums, accumulates the row and emits the result word.
    i8i4gdm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .head         (q_head),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // The front must never push more groups than the queue can hold.
    `I8I4GDM_NEVER(a_queue_overflow, q_push && q_stat.full, "group pushed into a full queue")
    // The back must only pop a group that is really there.
    `I8I4GDM_NEVER(a_queue_underflow, q_pop && q_stat.empty, "pop from an empty queue")
    // A pushed group is visible to the back in the next cycle.
    `I8I4GDM_ASSERT(a_push_lands, q_push |=> !q_stat.empty, "pushed group lost by the queue")

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the two-column group dequantizing MAC.
// A scoreboard object carries its own copy of the group sums, the row
// accumulators and the clip flag, folds in every input word that the block
// accepts, and queues one expected row result for each word that ends a row.
// Every result word that leaves the block is compared field by field against
// the oldest queued row.
module testbench;
    import i8i4gdm_pkg::*;

    localparam int HALF_PERIOD    = 2;
    localparam int RESET_CYCLES   = 3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_WORDS    = 300;

    // Reference behavior of the datapath, kept at the block's own widths.
    class dequant_scoreboard;
        longint  grp_even;
        longint  grp_odd;
        longint  row_even;
        longint  row_odd;
        bit      clip_seen;
        result_t rows_due[$];
        int      mismatches;
        int      words_in;
        int      rows_seen;
        int      rows_saturated;

        function new();
            clear_row();
            mismatches     = 0;
            words_in       = 0;
            rows_seen      = 0;
            rows_saturated = 0;
        endfunction

        function void clear_row();
            grp_even  = 0;
            grp_odd   = 0;
            row_even  = 0;
            row_odd   = 0;
            clip_seen = 1'b0;
        endfunction

        // Clip to a signed w-bit range and remember that a clip happened.
        function longint clip(longint v, int w);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (w - 1)) - 1;
            lo = -hi - 1;
            if (v > hi)
            begin
                clip_seen = 1'b1;
                return hi;
            end
            if (v < lo)
            begin
                clip_seen = 1'b1;
                return lo;
            end
            return v;
        endfunction

        // Group sum times both scales. The magnitude is rounded half away
        // from zero down to FRACTION_BITS and clipped before the sign goes back.
        function longint scaled_group(longint gsum, logic [SCALE_W-1:0] ascale,
                                      logic [SCALE_W-1:0] wscale);
            logic [127:0] mag;
            logic [127:0] exact;
            logic [127:0] lim;
            bit           neg;
            neg   = (gsum < 0);
            mag   = neg ? 128'(-gsum) : 128'(gsum);
            exact = mag * 128'(ascale) * 128'(wscale)
                    + (128'(1) << (FRACTION_BITS - 1));
            exact = exact >> FRACTION_BITS;
            lim   = 128'((longint'(1) <<< (ACC_WIDTH - 1)) - 1) + 128'(neg);
            if (exact > lim)
            begin
                clip_seen = 1'b1;
                exact     = lim;
            end
            return neg ? -$signed(exact[63:0]) : $signed(exact[63:0]);
        endfunction

        function void take_step(step_t s);
            longint  act;
            longint  w_even;
            longint  w_odd;
            longint  sum_even;
            longint  sum_odd;
            result_t r;
            words_in++;
            act    = longint'(s.act_byte) - longint'(s.act_zero);
            w_even = longint'(s.weight_pair[NIBBLE_W-1:0]) - longint'($signed(s.wzero_even));
            w_odd  = longint'(s.weight_pair[NIBBLE_W +: NIBBLE_W])
                     - longint'($signed(s.wzero_odd));
            grp_even = clip(grp_even + act * w_even, WORD_W);
            grp_odd  = clip(grp_odd + act * w_odd, WORD_W);
            if (s.group_last || s.row_last)
            begin
                row_even = clip(row_even + scaled_group(grp_even, s.act_scale, s.wscale_even),
                                ACC_WIDTH);
                row_odd  = clip(row_odd + scaled_group(grp_odd, s.act_scale, s.wscale_odd),
                                ACC_WIDTH);
                grp_even = 0;
                grp_odd  = 0;
            end
            if (s.row_last)
            begin
                sum_even = clip(clip(row_even + longint'($signed(s.bias_even)), ACC_WIDTH),
                                OUT_WIDTH);
                sum_odd  = clip(clip(row_odd + longint'($signed(s.bias_odd)), ACC_WIDTH),
                                OUT_WIDTH);
                r.out_even  = sum_even[OUT_WIDTH-1:0];
                r.out_odd   = sum_odd[OUT_WIDTH-1:0];
                r.saturated = clip_seen;
                rows_due.push_back(r);
                clear_row();
            end
        endfunction

        function void check_row(result_t got);
            result_t want;
            rows_seen++;
            if (got.saturated)
                rows_saturated++;
            if (rows_due.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: result word with no row pending: even %0d odd %0d sat %0b",
                         $time, got.out_even, got.out_odd, got.saturated);
                return;
            end
            want = rows_due.pop_front();
            if (got.out_even !== want.out_even)
            begin
                mismatches++;
                $display("%0t ns: out_even expected %0d, got %0d",
                         $time, want.out_even, got.out_even);
            end
            if (got.out_odd !== want.out_odd)
            begin
                mismatches++;
                $display("%0t ns: out_odd expected %0d, got %0d",
                         $time, want.out_odd, got.out_odd);
            end
            if (got.saturated !== want.saturated)
            begin
                mismatches++;
                $display("%0t ns: saturated expected %0b, got %0b",
                         $time, want.saturated, got.saturated);
            end
        endfunction
    endclass

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    step_valid   = 1'b0;
    logic    step_ready;
    step_t   step_word    = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t row_result;

    // Pacing knobs, in percent per cycle, and the watchdog's count of quiet edges.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    dequant_scoreboard sb = new();

    int8_int4_group_dequant_mac i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_valid   (step_valid),
        .step_ready   (step_ready),
        .step         (step_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (row_result)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // The receiver drops ready at random while a stall percentage is set.
    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Both channels are observed at the edge where a word moves. Values read
    // here are the ones the block itself sampled at that edge. The watchdog
    // counts edges at which neither channel moved a word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (step_valid && step_ready)
                sb.take_step(step_word);
            if (result_valid && result_ready)
                sb.check_row(row_result);
            if ((step_valid && step_ready) || (result_valid && result_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("%0t ns: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
                    $display("FAIL int8_int4_group_dequant_mac");
                    $finish;
                end
            end
        end
    end

    // Offer one word and hold it until the block takes it. Idle cycles are
    // inserted before the word only; once valid is up it stays up.
    task automatic send_step(input step_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            step_valid <= 1'b0;
            @(posedge clk);
        end
        step_valid <= 1'b1;
        step_word  <= s;
        @(posedge clk);
        while (!step_ready)
            @(posedge clk);
    endtask

    // Lower valid and hold off until every queued row has come back.
    task automatic wait_rows_done();
        step_valid <= 1'b0;
        @(posedge clk);
        while (sb.rows_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic step_t unit_step();
        step_t s;
        s             = '0;
        s.act_scale   = SCALE_W'(1 << FRACTION_BITS);
        s.wscale_even = SCALE_W'(1 << FRACTION_BITS);
        s.wscale_odd  = SCALE_W'(1 << FRACTION_BITS);
        return s;
    endfunction

    // Scales are mostly between 0 and 2.0 so that rows stay in range, with some full
    // random values and the two extremes mixed in.
    function automatic logic [SCALE_W-1:0] random_scale();
        case ($urandom_range(7))
            0: return SCALE_W'($urandom);
            1: return '0;
            2: return {SCALE_W{1'b1}};
            default: return SCALE_W'($urandom_range(32'h0002_0000));
        endcase
    endfunction

    function automatic logic signed [BIAS_W-1:0] random_bias();
        case ($urandom_range(3))
            0: return '0;
            1: return $urandom;
            default: return $signed(32'($urandom_range(32'h00ff_ffff))) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic step_t random_step();
        step_t s;
        s             = '0;
        s.act_byte    = 8'($urandom);
        s.act_zero    = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
        s.weight_pair = 8'($urandom);
        // Real int4 zero points sit in 0..15, but the field takes any byte.
        s.wzero_even  = ($urandom_range(3) != 0) ? 8'($urandom_range(15)) : 8'($urandom);
        s.wzero_odd   = ($urandom_range(3) != 0) ? 8'($urandom_range(15)) : 8'($urandom);
        s.act_scale   = random_scale();
        s.wscale_even = random_scale();
        s.wscale_odd  = random_scale();
        s.bias_even   = random_bias();
        s.bias_odd    = random_bias();
        return s;
    endfunction

    // Hand-picked rows: field extremes, the row end that also closes a
    // group, rounding ties on both signs, an activation scale of zero, a bias that is
    // ignored before the row end, and clipping of the row accumulators.
    task automatic run_directed();
        step_t s;
        // Largest positive products with every scale at its maximum and the
        // largest bias, so the scaled term and the bias sum both clip.
        s             = unit_step();
        s.act_byte    = 8'hff;
        s.weight_pair = 8'hff;
        s.wzero_even  = 8'sh80;
        s.wzero_odd   = 8'sh80;
        s.act_scale   = {SCALE_W{1'b1}};
        s.wscale_even = {SCALE_W{1'b1}};
        s.wscale_odd  = {SCALE_W{1'b1}};
        s.group_last  = 1'b1;
        s.row_last    = 1'b1;
        s.bias_even   = 32'sh7fff_ffff;
        s.bias_odd    = 32'sh7fff_ffff;
        send_step(s);
        // Most negative activation times most negative weight difference,
        // row end without the group mark, most negative bias.
        s.act_byte    = 8'h00;
        s.act_zero    = 8'hff;
        s.weight_pair = 8'h00;
        s.wzero_even  = 8'sd127;
        s.wzero_odd   = 8'sd127;
        s.group_last  = 1'b0;
        s.bias_even   = 32'sh8000_0000;
        s.bias_odd    = 32'sh8000_0000;
        send_step(s);
        // Negative products at full scale clip the row at the bottom.
        s.weight_pair = 8'hff;
        s.wzero_even  = 8'sh80;
        s.wzero_odd   = 8'sh80;
        send_step(s);
        // A zero activation scale leaves only the bias.
        s             = unit_step();
        s.act_byte    = 8'd200;
        s.act_zero    = 8'd3;
        s.weight_pair = 8'h5a;
        s.wzero_even  = 8'sd2;
        s.wzero_odd   = -8'sd3;
        s.act_scale   = '0;
        s.row_last    = 1'b1;
        s.bias_even   = 32'sd12345;
        s.bias_odd    = -32'sd999;
        send_step(s);
        // Exact half-way results round away from zero, for both signs.
        s             = unit_step();
        s.act_byte    = 8'd1;
        s.weight_pair = 8'h21;
        s.act_scale   = SCALE_W'(1);
        s.wscale_even = SCALE_W'(1 << (FRACTION_BITS - 1));
        s.wscale_odd  = SCALE_W'(3 << (FRACTION_BITS - 2));
        s.row_last    = 1'b1;
        send_step(s);
        s.act_byte    = 8'd0;
        s.act_zero    = 8'd1;
        send_step(s);
        // Just under half rounds toward zero on the even column; odd is again a tie.
        s.wscale_even = SCALE_W'((1 << (FRACTION_BITS - 1)) - 1);
        s.wscale_odd  = SCALE_W'(1 << (FRACTION_BITS - 2));
        send_step(s);
        // Three groups in one row; the bias on the inner words must not count.
        for (int i = 0; i < 5; i++)
        begin
            s             = unit_step();
            s.act_byte    = 8'(37 * i + 11);
            s.act_zero    = 8'(100 + i);
            s.weight_pair = 8'(8'h3c + i * 8'h11);
            s.wzero_even  = 8'(i);
            s.wzero_odd   = 8'(8 - 3 * i);
            s.bias_even   = 32'sd77777;
            s.bias_odd    = -32'sd5;
            s.group_last  = (i == 1) || (i == 3);
            s.row_last    = (i == 4);
            send_step(s);
        end
        // Two groups whose terms fit on their own but overflow the row
        // accumulator together, upward on the even column, downward on odd.
        s             = unit_step();
        s.act_byte    = 8'hff;
        s.weight_pair = 8'hff;
        s.wzero_even  = 8'sh80;
        s.wzero_odd   = 8'sd127;
        s.act_scale   = {SCALE_W{1'b1}};
        s.wscale_even = SCALE_W'(32'h0001_8000);
        s.wscale_odd  = SCALE_W'(32'h0001_8000);
        s.group_last  = 1'b1;
        send_step(s);
        s.group_last  = 1'b0;
        s.row_last    = 1'b1;
        send_step(s);
    endtask

    // Random rows of 1 to 12 words, now and then longer, cut into groups of
    // 1 to 8 words. About one row in ten puts the group mark at random.
    task automatic send_rows(input int n_words);
        step_t s;
        int    sent;
        int    row_len;
        int    grp_len;
        int    in_grp;
        bit    noisy;
        sent = 0;
        while (sent < n_words)
        begin
            row_len = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            noisy   = ($urandom_range(9) == 0);
            grp_len = $urandom_range(8, 1);
            in_grp  = 0;
            for (int i = 0; i < row_len; i++)
            begin
                s = random_step();
                in_grp++;
                if (noisy)
                    s.group_last = $urandom_range(1);
                else if (in_grp == grp_len)
                begin
                    s.group_last = 1'b1;
                    in_grp       = 0;
                    grp_len      = $urandom_range(8, 1);
                end
                s.row_last = (i == row_len - 1);
                send_step(s);
                sent++;
            end
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n_words);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        send_rows(n_words);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Free-flowing handshakes first.
        run_directed();
        run_phase(0, 0, PHASE_WORDS);
        // Sparse sender, then a full stop until the block has drained.
        run_phase(67, 0, PHASE_WORDS);
        wait_rows_done();
        // Slow receiver, then both sides pausing now and then.
        run_phase(0, 67, PHASE_WORDS);
        run_phase(27, 27, PHASE_WORDS);

        wait_rows_done();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d input words under four pacing patterns.", sb.words_in);
        $display("Checked %0d row results, %0d of them with the saturation flag set.",
                 sb.rows_seen, sb.rows_saturated);
        if (sb.mismatches == 0 && sb.rows_due.size() == 0)
            $display("PASS int8_int4_group_dequant_mac");
        else
            $display("FAIL int8_int4_group_dequant_mac");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/i8i4gdm_pkg.sv
rtl/core/i8i4gdm_front.sv
rtl/core/i8i4gdm_queue.sv
rtl/core/i8i4gdm_back.sv
rtl/core/int8_int4_group_dequant_mac.sv
test/testbench.sv
